[rtl/hsl2rgb_pkg.sv]
// shared widths, limits, pipeline depth and channel segment codes for the hsl to rgb converter
package hsl2rgb_pkg;

  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int HUE_MAX = 360;
  localparam int PCT_MAX = 100;

  // register stages from the accepting edge to the result strobe
  localparam int PIPE_DEPTH = 10;

  typedef logic [BYTE_W-1:0] byte_t;

  // which piece of the hue ramp a channel sits on
  typedef logic [1:0] seg_t;
  localparam seg_t SEG_RISE = 2'd0;
  localparam seg_t SEG_FLAT = 2'd1;
  localparam seg_t SEG_FALL = 2'd2;
  localparam seg_t SEG_LOW  = 2'd3;

endpackage

[rtl/hsl_to_rgb_converter.sv]
// hsl to rgb converter top level: ten-stage pipeline from hue, saturation, lightness to rgb bytes
// the strobe is the last bit of the valid line (PIPE_DEPTH) and comes out together with the result bytes
// throughput: one word per cycle, busy is high only while rst_n is low, every stage advances
// the longest stages hold one multiplier (lightness times saturation, ramp, byte scaling)
// reset: synchronous active-low rst_n clears the valid line only, no result leaves the pipe
// during or after reset unless a word was accepted; the receiver cannot stall the strobe
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]       in_hue_deg,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]       in_sat_pct,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]       in_light_pct,
  input  logic [hsl2rgb_pkg::BYTE_W-1:0]      in_alpha_code,
  output logic                                out_valid,
  output hsl2rgb_pkg::byte_t                  out_red,
  output hsl2rgb_pkg::byte_t                  out_green,
  output hsl2rgb_pkg::byte_t                  out_blue,
  output hsl2rgb_pkg::byte_t                  out_alpha_out
);
  import hsl2rgb_pkg::*;

  localparam int FW    = FRAC_BITS + 1;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int HALF  = ONE / 2;
  localparam int THIRD = ONE / 3;

  logic accept;

  // stage 1: saturated inputs
  logic [HUE_W-1:0] h1_r, h1_nxt;
  logic [PCT_W-1:0] s1_r, s1_nxt;
  logic [PCT_W-1:0] l1_r, l1_nxt;

  // stages 2 to 4: fixed-point fractions
  logic [FW-1:0] hf4, sf4, lf4;

  // stage 5: lightness times saturation
  logic [2*FW-1:0] ls_prod;
  logic [FW-1:0]   prod5_r, hf5_r, sf5_r, lf5_r;

  // stage 6: q level and the three channel hue positions
  logic [FW:0]   q_sum;
  logic [FW-1:0] q6_r, q6_nxt;
  logic [FW-1:0] lf6_r;
  logic [FW:0]   tr_sum;
  logic [FW-1:0] tr6_r, tr6_nxt;
  logic [FW-1:0] tg6_r;
  logic [FW-1:0] tb6_r, tb6_nxt;

  // stage 7: p level, clamped into 0..q
  logic [FW:0]   twol;
  logic [FW:0]   p_raw;
  logic [FW-1:0] p7_r, p7_nxt;
  logic [FW-1:0] q7_r;

  // valid and alpha travel alongside the data
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  byte_t                 alpha_r [PIPE_DEPTH];

  // no word is taken while reset holds the valid line clear
  assign busy   = ~rst_n;
  assign accept = start && !busy;

  // out-of-range inputs clip to their top value
  assign h1_nxt = (in_hue_deg > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : in_hue_deg;
  assign s1_nxt = (in_sat_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_sat_pct;
  assign l1_nxt = (in_light_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_light_pct;

  hsl2rgb_scale #(.FRAC_BITS(FRAC_BITS), .DIV(HUE_MAX), .VW(HUE_W)) u_hue_scale (
    .clk  (clk),
    .val  (h1_r),
    .frac (hf4)
  );

  hsl2rgb_scale #(.FRAC_BITS(FRAC_BITS), .DIV(PCT_MAX), .VW(PCT_W)) u_sat_scale (
    .clk  (clk),
    .val  (s1_r),
    .frac (sf4)
  );

  hsl2rgb_scale #(.FRAC_BITS(FRAC_BITS), .DIV(PCT_MAX), .VW(PCT_W)) u_light_scale (
    .clk  (clk),
    .val  (l1_r),
    .frac (lf4)
  );

  assign ls_prod = (2*FW)'(lf4) * (2*FW)'(sf4);

  // zero saturation needs no bypass: prod is zero, so q = p = lightness and every
  // channel lands on the lightness level (grey)
  always_comb begin
    if (lf5_r < FW'(HALF)) begin
      q_sum = (FW+1)'(lf5_r) + (FW+1)'(prod5_r);
    end else begin
      q_sum = (FW+1)'(lf5_r) + (FW+1)'(sf5_r) - (FW+1)'(prod5_r);
    end
    q6_nxt = (q_sum > (FW+1)'(ONE)) ? FW'(ONE) : q_sum[FW-1:0];
  end

  // hue positions wrapped back into 0..one
  always_comb begin
    tr_sum  = (FW+1)'(hf5_r) + (FW+1)'(THIRD);
    tr6_nxt = (tr_sum > (FW+1)'(ONE)) ? FW'(tr_sum - (FW+1)'(ONE)) : tr_sum[FW-1:0];
    tb6_nxt = (hf5_r < FW'(THIRD)) ? hf5_r + FW'(ONE - THIRD) : hf5_r - FW'(THIRD);
  end

  always_comb begin
    twol  = {lf6_r, 1'b0};
    p_raw = (twol < (FW+1)'(q6_r)) ? '0 : twol - (FW+1)'(q6_r);
    p7_nxt = (p_raw > (FW+1)'(q6_r)) ? q6_r : p_raw[FW-1:0];
  end

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red_chan (
    .clk       (clk),
    .t         (tr6_r),
    .p         (p7_r),
    .q         (q7_r),
    .chan_byte (out_red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green_chan (
    .clk       (clk),
    .t         (tg6_r),
    .p         (p7_r),
    .q         (q7_r),
    .chan_byte (out_green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue_chan (
    .clk       (clk),
    .t         (tb6_r),
    .p         (p7_r),
    .q         (q7_r),
    .chan_byte (out_blue)
  );

  // valid line: one bit per stage, the last one is the result strobe
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // data path registers, no reset needed
  always_ff @(posedge clk) begin
    h1_r    <= h1_nxt;
    s1_r    <= s1_nxt;
    l1_r    <= l1_nxt;
    prod5_r <= FW'(ls_prod >> FRAC_BITS);
    hf5_r   <= hf4;
    sf5_r   <= sf4;
    lf5_r   <= lf4;
    q6_r    <= q6_nxt;
    lf6_r   <= lf5_r;
    tr6_r   <= tr6_nxt;
    tg6_r   <= hf5_r;
    tb6_r   <= tb6_nxt;
    p7_r    <= p7_nxt;
    q7_r    <= q6_r;
  end

  // alpha rides a plain delay line to line up with the color bytes
  always_ff @(posedge clk) begin
    alpha_r[0] <= in_alpha_code;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      alpha_r[i] <= alpha_r[i-1];
    end
  end

  assign out_valid     = vld_r[PIPE_DEPTH-1];
  assign out_alpha_out = alpha_r[PIPE_DEPTH-1];

endmodule

[rtl/hsl2rgb_scale.sv]
// three-stage exact floor(val * 2^frac_bits / div) by reciprocal multiply and one correction
module hsl2rgb_scale #(
  parameter int FRAC_BITS = 16,
  parameter int DIV       = 100,
  parameter int VW        = 7
) (
  input  logic                 clk,
  input  logic [VW-1:0]        val,
  output logic [FRAC_BITS:0]   frac
);
  import hsl2rgb_pkg::*;

  localparam int FW  = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int QD  = ONE / DIV;
  localparam int RD  = ONE % DIV;
  // val is at most div, so the remainder product stays below div squared
  localparam int XW  = $clog2(DIV * DIV);
  localparam int M   = (1 << XW) / DIV;
  localparam int MW  = $clog2(M + 1);
  localparam int QW  = $clog2(DIV);
  localparam int PW  = XW + MW;

  logic [FW-1:0] base1_r, base1_nxt;
  logic [XW-1:0] x1_r, x1_nxt;
  logic [FW-1:0] base2_r;
  logic [XW-1:0] x2_r;
  logic [QW-1:0] q0_r, q0_nxt;
  logic [PW-1:0] pm;
  logic [XW-1:0] rem;
  logic          fix;
  logic [FW-1:0] frac_r, frac_nxt;

  // split into whole quotient part and remainder part
  assign base1_nxt = FW'(val) * FW'(QD);
  assign x1_nxt    = XW'(val) * XW'(RD);

  // quotient estimate, low by at most one
  assign pm     = PW'(x1_r) * PW'(M);
  assign q0_nxt = QW'(pm >> XW);

  assign rem      = x2_r - XW'(q0_r) * XW'(DIV);
  assign fix      = (rem >= XW'(DIV));
  assign frac_nxt = base2_r + FW'(q0_r) + FW'(fix);

  always_ff @(posedge clk) begin
    base1_r <= base1_nxt;
    x1_r    <= x1_nxt;
    base2_r <= base1_r;
    x2_r    <= x1_r;
    q0_r    <= q0_nxt;
    frac_r  <= frac_nxt;
  end

  assign frac = frac_r;

endmodule

[rtl/hsl2rgb_chan.sv]
// one color channel: ramp segment, ramp multiply, level select and byte scaling over four stages
module hsl2rgb_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic [FRAC_BITS:0]  t,
  input  logic [FRAC_BITS:0]  p,
  input  logic [FRAC_BITS:0]  q,
  output hsl2rgb_pkg::byte_t  chan_byte
);
  import hsl2rgb_pkg::*;

  localparam int FW        = FRAC_BITS + 1;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int SIXTH     = ONE / 6;
  localparam int HALF      = ONE / 2;
  localparam int TWO_THIRD = (2 * ONE) / 3;

  seg_t          seg7_r, seg7_nxt;
  logic [FW-1:0] u;
  logic [FW-1:0] f7_r, f7_nxt;
  logic [FW-1:0] d;
  logic [2*FW-1:0] mp;
  logic [FW-1:0] mult8_r;
  logic [FW-1:0] p8_r, q8_r;
  seg_t          seg8_r;
  logic [FW-1:0] v9_r, v9_nxt;
  logic [FW+7:0] bw;
  logic [FW+7:0] bsh;
  byte_t         byte_r, byte_nxt;

  always_comb begin
    if (t < FW'(SIXTH)) begin
      seg7_nxt = SEG_RISE;
      u        = t;
    end else if (t < FW'(HALF)) begin
      seg7_nxt = SEG_FLAT;
      u        = '0;
    end else if (t < FW'(TWO_THIRD)) begin
      seg7_nxt = SEG_FALL;
      u        = FW'(TWO_THIRD) - t;
    end else begin
      seg7_nxt = SEG_LOW;
      u        = '0;
    end
    f7_nxt = u * FW'(6);
  end

  assign d  = q - p;
  assign mp = (2*FW)'(d) * (2*FW)'(f7_r);

  always_comb begin
    case (seg8_r)
      SEG_RISE: v9_nxt = p8_r + mult8_r;
      SEG_FLAT: v9_nxt = q8_r;
      SEG_FALL: v9_nxt = p8_r + mult8_r;
      SEG_LOW:  v9_nxt = p8_r;
      default:  v9_nxt = p8_r;
    endcase
  end

  assign bw       = (FW+8)'(v9_r) * (FW+8)'(255);
  assign bsh      = bw >> FRAC_BITS;
  assign byte_nxt = (bsh > (FW+8)'(255)) ? '1 : bsh[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    seg7_r  <= seg7_nxt;
    f7_r    <= f7_nxt;
    mult8_r <= FW'(mp >> FRAC_BITS);
    p8_r    <= p;
    q8_r    <= q;
    seg8_r  <= seg7_r;
    v9_r    <= v9_nxt;
    byte_r  <= byte_nxt;
  end

  assign chan_byte = byte_r;

endmodule

[rtl/hsl2rgb_checker.sv]
// port-level checker for the hsl to rgb converter and its bind to the top level
module hsl2rgb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [hsl2rgb_pkg::HUE_W-1:0]   in_hue_deg,
  input logic [hsl2rgb_pkg::PCT_W-1:0]   in_sat_pct,
  input logic [hsl2rgb_pkg::PCT_W-1:0]   in_light_pct,
  input logic [hsl2rgb_pkg::BYTE_W-1:0]  in_alpha_code,
  input logic                            out_valid,
  input hsl2rgb_pkg::byte_t              out_red,
  input hsl2rgb_pkg::byte_t              out_green,
  input hsl2rgb_pkg::byte_t              out_blue,
  input hsl2rgb_pkg::byte_t              out_alpha_out
);
  import hsl2rgb_pkg::*;

  // the pipe never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0)
    else $error("busy raised");

  // every strobe traces back to an accepted word a fixed depth earlier
  a_strobe_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, PIPE_DEPTH))
    else $error("result strobe without accepted word");

  // alpha lines up with its color
  a_alpha_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha_out == $past(in_alpha_code, PIPE_DEPTH)))
    else $error("alpha out of line with color");

  // zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_sat_pct == '0, PIPE_DEPTH))
      |-> (out_red == out_green && out_green == out_blue))
    else $error("zero saturation not grey");

  // zero lightness gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_light_pct == '0, PIPE_DEPTH))
      |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("zero lightness not black");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_hue_deg    (in_hue_deg),
  .in_sat_pct    (in_sat_pct),
  .in_light_pct  (in_light_pct),
  .in_alpha_code (in_alpha_code),
  .out_valid     (out_valid),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_alpha_out (out_alpha_out)
);

[test/hsl_to_rgb_converter_tb.sv]
// self-checking testbench for the hsl to rgb converter: directed corner colors, then random words
`timescale 1ns / 100ps

module hsl_to_rgb_converter_tb;
  import hsl2rgb_pkg::*;

  // fixed-point format of the color math, same as the block's default
  localparam int     FRAC_BITS    = 16;
  localparam longint FX_ONE       = longint'(1) << FRAC_BITS;
  localparam longint FX_HALF      = FX_ONE / 2;
  localparam longint FX_SIXTH     = FX_ONE / 6;
  localparam longint FX_THIRD     = FX_ONE / 3;
  localparam longint FX_TWO_THIRD = (2 * FX_ONE) / 3;

  // cycles with no word moving on either side before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1000;

  // one expected result word, field for field
  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
  } rgba_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic [HUE_W-1:0]   in_hue_deg    = '0;
  logic [PCT_W-1:0]   in_sat_pct    = '0;
  logic [PCT_W-1:0]   in_light_pct  = '0;
  logic [BYTE_W-1:0]  in_alpha_code = '0;
  logic               out_valid;
  byte_t              out_red;
  byte_t              out_green;
  byte_t              out_blue;
  byte_t              out_alpha_out;

  // colors predicted for accepted words, oldest first
  rgba_t pending_colors[$];
  int    mismatch_count = 0;
  int    idle_cycles    = 0;
  // set at the falling edge when the coming rising edge accepts the driven word
  bit    word_taken     = 1'b0;
  // random gaps between words on or off, switched in stretches by the random test
  bit    gaps_on        = 1'b1;

  hsl_to_rgb_converter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_hue_deg   (in_hue_deg),
    .in_sat_pct   (in_sat_pct),
    .in_light_pct (in_light_pct),
    .in_alpha_code(in_alpha_code),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha_out(out_alpha_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // color predictor, fixed point with truncation everywhere
  // ---------------------------------------------------------------------------

  // level of one channel on the hue ramp: rising, flat high, falling, flat low
  function automatic longint ramp_level(longint p, longint q, longint t);
    longint span;
    span = q - p;
    // wrap the channel's hue offset back into one turn
    if (t < 0) t += FX_ONE;
    if (t > FX_ONE) t -= FX_ONE;
    if (t < FX_SIXTH) return p + ((span * 6 * t) >>> FRAC_BITS);
    if (t < FX_HALF) return q;
    if (t < FX_TWO_THIRD) return p + ((span * (FX_TWO_THIRD - t) * 6) >>> FRAC_BITS);
    return p;
  endfunction

  // fraction of one scaled to a byte, floor, clamped at full scale
  function automatic byte_t frac_to_byte(longint v);
    longint b;
    if (v < 0) v = 0;
    b = (v * 255) >>> FRAC_BITS;
    return (b > 255) ? byte_t'(255) : byte_t'(b);
  endfunction

  function automatic rgba_t predict_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                          logic [PCT_W-1:0] light, byte_t alpha);
    longint h, s, l, hf, sf, lf, prod, q, p;
    rgba_t  c;
    // out-of-range inputs pin to their top value
    h  = (longint'(hue) > HUE_MAX) ? HUE_MAX : longint'(hue);
    s  = (longint'(sat) > PCT_MAX) ? PCT_MAX : longint'(sat);
    l  = (longint'(light) > PCT_MAX) ? PCT_MAX : longint'(light);
    hf = (h * FX_ONE) / HUE_MAX;
    sf = (s * FX_ONE) / PCT_MAX;
    lf = (l * FX_ONE) / PCT_MAX;
    if (sf == 0) begin
      // no saturation: plain grey at the lightness level
      c.red   = frac_to_byte(lf);
      c.green = c.red;
      c.blue  = c.red;
    end else begin
      prod = (lf * sf) >>> FRAC_BITS;
      q    = (lf < FX_HALF) ? lf + prod : lf + sf - prod;
      if (q > FX_ONE) q = FX_ONE;
      if (q < 0) q = 0;
      p = 2 * lf - q;
      if (p < 0) p = 0;
      if (p > q) p = q;
      c.red   = frac_to_byte(ramp_level(p, q, hf + FX_THIRD));
      c.green = frac_to_byte(ramp_level(p, q, hf));
      c.blue  = frac_to_byte(ramp_level(p, q, hf - FX_THIRD));
    end
    c.alpha = alpha;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // random picks
  // ---------------------------------------------------------------------------

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hue mostly in range, with the ends and the over-range codes mixed in
  function automatic logic [HUE_W-1:0] pick_hue();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return HUE_W'($urandom_range(HUE_MAX + 1, (1 << HUE_W) - 1));
    if (r == 1) return HUE_W'(HUE_MAX);
    if (r == 2) return '0;
    return HUE_W'($urandom_range(0, HUE_MAX - 1));
  endfunction

  // percent mostly in range, with the ends and the over-range codes mixed in
  function automatic logic [PCT_W-1:0] pick_pct();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return PCT_W'($urandom_range(PCT_MAX + 1, (1 << PCT_W) - 1));
    if (r == 1) return '0;
    if (r == 2) return PCT_W'(PCT_MAX);
    return PCT_W'($urandom_range(0, PCT_MAX));
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one word per call, held until the block takes it
  // ---------------------------------------------------------------------------

  // called right after a rising edge; returns right after the accepting edge or after the gap
  // that follows it, with start still high when no gap follows so words can go back to back
  task automatic send_color(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] light, input byte_t alpha);
    int gap;
    start         <= 1'b1;
    in_hue_deg    <= hue;
    in_sat_pct    <= sat;
    in_light_pct  <= light;
    in_alpha_code <= alpha;
    @(posedge clk);
    while (!word_taken) @(posedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side and watchdog, sampled at the falling edge so nothing races
  // the rising edge: what is seen here is what the next rising edge takes
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input byte_t want, input byte_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin : result_monitor
    rgba_t want;
    word_taken = rst_n && start && !busy;
    // the word on the input ports is taken at the coming edge: predict it now
    if (word_taken)
      pending_colors = {pending_colors,
                        predict_color(in_hue_deg, in_sat_pct, in_light_pct, in_alpha_code)};
    // a strobe, or an unknown strobe, out of reset is a result to account for
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: result word with none pending, expected nothing actual %h %h %h %h",
                 $time, out_red, out_green, out_blue, out_alpha_out);
        mismatch_count++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha_out);
      end
    end
    // hang detection: any word moving on either side restarts the count
    if (word_taken || (rst_n && out_valid === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all-zero and all-full words, plus near-end values on every field
  task automatic test_corner_values();
    send_color(9'd0, 7'd0, 7'd0, 8'h00);
    send_color(9'd360, 7'd100, 7'd100, 8'hff);
    send_color(9'd0, 7'd100, 7'd50, 8'haa);
    send_color(9'd359, 7'd100, 7'd50, 8'h55);
    send_color(9'd180, 7'd1, 7'd1, 8'h01);
    send_color(9'd1, 7'd99, 7'd99, 8'hfe);
  endtask

  // zero saturation gives grey at the lightness, whatever the hue
  task automatic test_grey_axis();
    send_color(9'd0, 7'd0, 7'd0, 8'h10);
    send_color(9'd90, 7'd0, 7'd25, 8'h20);
    send_color(9'd200, 7'd0, 7'd50, 8'h40);
    send_color(9'd300, 7'd0, 7'd75, 8'h80);
    send_color(9'd360, 7'd0, 7'd100, 8'hc3);
  endtask

  // every sixth of the hue circle, both lightness halves
  task automatic test_hue_sectors();
    send_color(9'd0, 7'd100, 7'd50, 8'hff);
    send_color(9'd60, 7'd100, 7'd50, 8'hff);
    send_color(9'd120, 7'd100, 7'd50, 8'hff);
    send_color(9'd180, 7'd100, 7'd50, 8'hff);
    send_color(9'd240, 7'd100, 7'd50, 8'hff);
    send_color(9'd300, 7'd100, 7'd50, 8'hff);
    // dark and light side of the lightness split
    send_color(9'd90, 7'd70, 7'd30, 8'h3c);
    send_color(9'd270, 7'd40, 7'd80, 8'hc3);
  endtask

  // codes beyond the ranges pin to hue 360 and 100 percent
  task automatic test_saturating_inputs();
    send_color(9'd511, 7'd127, 7'd127, 8'hff);
    send_color(9'd361, 7'd101, 7'd50, 8'h00);
    send_color(9'd200, 7'd127, 7'd20, 8'h80);
    send_color(9'd100, 7'd60, 7'd101, 8'h03);
    send_color(9'd300, 7'd0, 7'd127, 8'h4d);
  endtask

  // random words, in stretches with and without gaps between them
  task automatic test_random_colors();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_color(pick_hue(), pick_pct(), pick_pct(), byte_t'($urandom_range(0, 255)));
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // synchronous reset held at the start, released once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_values();
    test_grey_axis();
    test_hue_sectors();
    test_saturating_inputs();
    test_random_colors();
    start <= 1'b0;

    // drain: every predicted word has to come out, the watchdog bounds the wait
    while (pending_colors.size() != 0) @(posedge clk);
    // then a further wait, longer than the pipe, to catch any stray strobe
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[hsl_to_rgb_converter.f]
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_scale.sv
rtl/hsl2rgb_chan.sv
rtl/hsl_to_rgb_converter.sv
rtl/hsl2rgb_checker.sv
test/hsl_to_rgb_converter_tb.sv
